[sv/bbia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_pkg
// Shared widths, codes and controller/datapath types of the bitmap
// block/inode allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

  // field widths
  localparam int OP_W  = 3;
  localparam int TGT_W = 32;
  localparam int CFG_W = 32;
  localparam int IDX_W = 2;
  localparam int NUM_W = 14;
  localparam int ST_W  = 2;
  localparam int CNT_W = 16;

  // map organisation
  localparam int WORD_BITS = 64;
  localparam int WORD_SH   = 6;

  // parameter defaults
  localparam int MAP_BITS_DEF          = 8192;
  localparam int FIRST_INODE_INDEX_DEF = 10;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC_BLOCK = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE_BLOCK  = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_FILE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC_DIR   = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE_INODE  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE        = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE        = 2'd1;
  localparam logic [ST_W-1:0] ST_ALREADY_CLR = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TOTAL_BLOCKS     = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOTAL_INODES     = 2'd1;
  localparam logic [IDX_W-1:0] REG_INODES_PER_GROUP = 2'd2;
  localparam logic [IDX_W-1:0] REG_DEVICE_BLOCKS    = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST     = 32'd8192;
  localparam logic [CFG_W-1:0] TOTAL_INODES_RST     = 32'd2048;
  localparam logic [CFG_W-1:0] INODES_PER_GROUP_RST = 32'd2048;
  localparam logic [CFG_W-1:0] DEVICE_BLOCKS_RST    = 32'd8192;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic alloc_commit;
    logic free_commit;
    logic fail;
    logic push;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic range_empty;
    logic free_ok;
    logic found;
    logic at_last;
    logic out_free;
  } sts_t;

endpackage

[sv/bbia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_if
// Request, response and register write channels of the allocator.
// ----------------------------------------------------------------------------
interface bbia_req_if;
  logic                       valid;
  logic                       ready;
  logic [bbia_pkg::OP_W-1:0]  operation;
  logic [bbia_pkg::TGT_W-1:0] target;

  modport source (output valid, output operation, output target, input ready);
  modport sink (input valid, input operation, input target, output ready);
endinterface

interface bbia_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bbia_pkg::NUM_W-1:0] number;
  logic [bbia_pkg::ST_W-1:0]  status;
  logic [bbia_pkg::CNT_W-1:0] free_blocks;
  logic [bbia_pkg::CNT_W-1:0] free_inodes;
  logic [bbia_pkg::CNT_W-1:0] used_dirs;

  modport source (output valid, output number, output status, output free_blocks,
                  output free_inodes, output used_dirs, input ready);
  modport sink (input valid, input number, input status, input free_blocks,
                input free_inodes, input used_dirs, output ready);
endinterface

interface bbia_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bbia_pkg::IDX_W-1:0] index;
  logic [bbia_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/bbia_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_datapath
// Configuration registers, the two bitmap memories, the scan window logic,
// the free counters and the response register.
// ----------------------------------------------------------------------------
module bbia_datapath #(
  parameter int MAP_BITS          = bbia_pkg::MAP_BITS_DEF,
  parameter int FIRST_INODE_INDEX = bbia_pkg::FIRST_INODE_INDEX_DEF,
  parameter int MAP_WORDS         = (MAP_BITS + bbia_pkg::WORD_BITS - 1) / bbia_pkg::WORD_BITS,
  parameter int WAW               = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // register writes
  input  logic                       cfg_valid_i,
  input  logic [bbia_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [bbia_pkg::CFG_W-1:0] cfg_data_i,
  // request payload
  input  logic [bbia_pkg::OP_W-1:0]  op_i,
  input  logic [bbia_pkg::TGT_W-1:0] target_i,
  // controller interface
  input  bbia_pkg::cmd_t             cmd_i,
  input  logic [WAW-1:0]             addr_i,
  output bbia_pkg::sts_t             sts_o,
  output logic [WAW-1:0]             start_w_o,
  output logic [WAW-1:0]             next_w_o,
  // response
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output logic [bbia_pkg::NUM_W-1:0] rsp_number_o,
  output logic [bbia_pkg::ST_W-1:0]  rsp_status_o,
  output logic [bbia_pkg::CNT_W-1:0] rsp_free_blocks_o,
  output logic [bbia_pkg::CNT_W-1:0] rsp_free_inodes_o,
  output logic [bbia_pkg::CNT_W-1:0] rsp_used_dirs_o
);
  import bbia_pkg::*;

  localparam int IW  = $clog2(MAP_BITS);
  localparam int NBW = WAW + WORD_SH + 1;
  localparam logic [CFG_W-1:0] MAP_LIM   = CFG_W'(MAP_BITS);
  localparam logic [IW:0]      FIRST_IDX = (IW + 1)'(FIRST_INODE_INDEX);

  // lowest set bit of a map word
  function automatic logic [WORD_SH-1:0] low_bit(input logic [WORD_BITS-1:0] v);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) r = WORD_SH'(k);
    end
    return r;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] tot_blk_q, tot_ino_q, ipg_q, dev_blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_blk_q <= TOTAL_BLOCKS_RST;
      tot_ino_q <= TOTAL_INODES_RST;
      ipg_q     <= INODES_PER_GROUP_RST;
      dev_blk_q <= DEVICE_BLOCKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TOTAL_BLOCKS:     tot_blk_q <= cfg_data_i;
        REG_TOTAL_INODES:     tot_ino_q <= cfg_data_i;
        REG_INODES_PER_GROUP: ipg_q     <= cfg_data_i;
        REG_DEVICE_BLOCKS:    dev_blk_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan window and free check, worked out as the request is taken
  logic [CFG_W-1:0] blk_lim, blk_lim_m1, ino_lim, tgt_m1;
  logic [IW:0]      blk_hi, ino_hi;
  logic             tgt_blk_ok, tgt_ino_ok, tgt_in_map;

  always_comb begin
    blk_lim    = (tot_blk_q < dev_blk_q) ? tot_blk_q : dev_blk_q;
    blk_lim_m1 = (blk_lim == '0) ? '0 : blk_lim - 1'b1;
    blk_hi     = (blk_lim_m1 < MAP_LIM) ? blk_lim_m1[IW:0] : MAP_LIM[IW:0];
    ino_lim    = (ipg_q < tot_ino_q) ? ipg_q : tot_ino_q;
    ino_hi     = (ino_lim < MAP_LIM) ? ino_lim[IW:0] : MAP_LIM[IW:0];
    tgt_blk_ok = (target_i != '0) && (target_i < tot_blk_q) && (target_i < dev_blk_q);
    tgt_ino_ok = (target_i != '0) && (target_i <= tot_ino_q);
    tgt_in_map = (target_i <= MAP_LIM);
    tgt_m1     = target_i - 1'b1;
  end

  logic [OP_W-1:0] op_q;
  logic [IW:0]     lo_q, hi_q;
  logic [IW-1:0]   idx_q;
  logic            free_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      idx_q <= tgt_m1[IW-1:0];
      if (op_i == OP_ALLOC_BLOCK) begin
        lo_q <= '0;
        hi_q <= blk_hi;
      end else begin
        lo_q <= FIRST_IDX;
        hi_q <= ino_hi;
      end
      free_ok_q <= tgt_in_map && ((op_i == OP_FREE_BLOCK) ? tgt_blk_ok : tgt_ino_ok);
    end
  end

  // bitmap memories, one 64-bit word per access
  logic                 is_blk;
  logic [WAW-1:0]       eval_w_q;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data, blk_rd_q, ino_rd_q, rd_word;
  logic                 blk_we, ino_we;
  logic [WORD_BITS-1:0] blk_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] ino_mem [MAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[wr_addr] <= wr_data;
    if (cmd_i.rd) blk_rd_q <= blk_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ino_we) ino_mem[wr_addr] <= wr_data;
    if (cmd_i.rd) ino_rd_q <= ino_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) eval_w_q <= addr_i;
  end

  // candidate bits of the word under test
  logic [WAW:0]         w_ext, hi_w;
  logic [WAW-1:0]       lo_w;
  logic [IW:0]          hi_m1;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, cand;
  logic [WORD_SH-1:0]   pos, free_b;
  logic                 free_bit;
  logic [NBW-1:0]       alloc_num;

  always_comb begin
    is_blk  = (op_q == OP_ALLOC_BLOCK) || (op_q == OP_FREE_BLOCK);
    rd_word = is_blk ? blk_rd_q : ino_rd_q;
    w_ext   = {1'b0, eval_w_q};
    lo_w    = WAW'(lo_q >> WORD_SH);
    hi_w    = (WAW + 1)'(hi_q >> WORD_SH);
    hi_m1   = hi_q - 1'b1;
    if (eval_w_q > lo_w) lo_mask = '1;
    else if (eval_w_q == lo_w) lo_mask = '1 << lo_q[WORD_SH-1:0];
    else lo_mask = '0;
    if (w_ext < hi_w) hi_mask = '1;
    else if (w_ext == hi_w) hi_mask = ~('1 << hi_q[WORD_SH-1:0]);
    else hi_mask = '0;
    cand      = ~rd_word & lo_mask & hi_mask;
    pos       = low_bit(cand);
    alloc_num = NBW'({eval_w_q, pos}) + 1'b1;
    free_b    = idx_q[WORD_SH-1:0];
    free_bit  = rd_word[free_b];
  end

  // write port: clearing pass, set on allocate, clear on free
  always_comb begin
    wr_addr = cmd_i.clr ? addr_i : eval_w_q;
    wr_data = '0;
    blk_we  = 1'b0;
    ino_we  = 1'b0;
    if (cmd_i.clr) begin
      blk_we = 1'b1;
      ino_we = 1'b1;
    end else if (cmd_i.alloc_commit) begin
      wr_data = rd_word | (WORD_BITS'(1) << pos);
      blk_we  = is_blk;
      ino_we  = !is_blk;
    end else if (cmd_i.free_commit && free_bit) begin
      wr_data = rd_word & ~(WORD_BITS'(1) << free_b);
      blk_we  = is_blk;
      ino_we  = !is_blk;
    end
  end

  // counters
  logic [CNT_W-1:0] fb_q, fi_q, ud_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= '0;
      fi_q <= '0;
      ud_q <= '0;
    end else if (cmd_i.alloc_commit) begin
      if (is_blk) fb_q <= fb_q - 1'b1;
      else fi_q <= fi_q - 1'b1;
      if (op_q == OP_ALLOC_DIR) ud_q <= ud_q + 1'b1;
    end else if (cmd_i.free_commit && free_bit) begin
      if (is_blk) fb_q <= fb_q + 1'b1;
      else fi_q <= fi_q + 1'b1;
    end
  end

  // result of the current item
  logic [NUM_W-1:0] res_num_q;
  logic [ST_W-1:0]  res_st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_commit) begin
      res_num_q <= NUM_W'(alloc_num);
      res_st_q  <= ST_DONE;
    end else if (cmd_i.free_commit) begin
      res_num_q <= '0;
      res_st_q  <= free_bit ? ST_DONE : ST_ALREADY_CLR;
    end else if (cmd_i.fail) begin
      res_num_q <= '0;
      res_st_q  <= ST_NONE;
    end
  end

  // response register
  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      rsp_number_o      <= res_num_q;
      rsp_status_o      <= res_st_q;
      rsp_free_blocks_o <= fb_q;
      rsp_free_inodes_o <= fi_q;
      rsp_used_dirs_o   <= ud_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  // status to the controller
  always_comb begin
    sts_o.is_alloc    = (op_q == OP_ALLOC_BLOCK) || (op_q == OP_ALLOC_FILE) ||
                        (op_q == OP_ALLOC_DIR);
    sts_o.is_free     = (op_q == OP_FREE_BLOCK) || (op_q == OP_FREE_INODE);
    sts_o.range_empty = (hi_q <= lo_q);
    sts_o.free_ok     = free_ok_q;
    sts_o.found       = |cand;
    sts_o.at_last     = (eval_w_q == WAW'(hi_m1 >> WORD_SH));
    sts_o.out_free    = !rsp_valid_q || rsp_ready_i;
    start_w_o         = sts_o.is_free ? WAW'(idx_q >> WORD_SH) : lo_w;
    next_w_o          = eval_w_q + 1'b1;
  end

endmodule

[sv/bbia_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_ctrl
// Sequencer of the allocator: clearing pass, request intake, word scan,
// free check and response hand-off.
// ----------------------------------------------------------------------------
module bbia_ctrl #(
  parameter int MAP_BITS  = bbia_pkg::MAP_BITS_DEF,
  parameter int MAP_WORDS = (MAP_BITS + bbia_pkg::WORD_BITS - 1) / bbia_pkg::WORD_BITS,
  parameter int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bbia_pkg::sts_t sts_i,
  input  logic [WAW-1:0] start_w_i,
  input  logic [WAW-1:0] next_w_i,
  output bbia_pkg::cmd_t cmd_o,
  output logic [WAW-1:0] addr_o
);
  import bbia_pkg::*;

  localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_SCAN,
    S_FCHK,
    S_PUSH
  } state_e;

  state_e         state_q, state_d;
  logic [WAW-1:0] clr_q, clr_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_o       = '0;
    addr_o      = clr_q;
    req_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_WORD) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RANGE;
        end
      end
      S_RANGE: begin
        addr_o = start_w_i;
        if (sts_i.is_alloc && !sts_i.range_empty) begin
          cmd_o.rd = 1'b1;
          state_d  = S_SCAN;
        end else if (sts_i.is_free && sts_i.free_ok) begin
          cmd_o.rd = 1'b1;
          state_d  = S_FCHK;
        end else begin
          cmd_o.fail = 1'b1;
          state_d    = S_PUSH;
        end
      end
      S_SCAN: begin
        addr_o = next_w_i;
        if (sts_i.found) begin
          cmd_o.alloc_commit = 1'b1;
          state_d            = S_PUSH;
        end else if (sts_i.at_last) begin
          cmd_o.fail = 1'b1;
          state_d    = S_PUSH;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      S_FCHK: begin
        cmd_o.free_commit = 1'b1;
        state_d           = S_PUSH;
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and clearing pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule

[sv/bitmap_block_inode_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_inode_allocator_unit
// First-fit block and inode bitmap allocator with free counters.
// ----------------------------------------------------------------------------
// After reset the unit clears both bitmaps one 64-bit word per cycle;
// requests are held off during that pass while register writes are taken.
// One request is handled at a time. A block or inode allocation scans one
// 64-bit map word per cycle, from the word holding the lowest usable bit to
// the word holding the first clear one or the last word of the window; the
// single read port of each bitmap memory sets that pace. A free reads the
// word that holds its target and then commits, and an unknown operation, an
// empty window or a rejected free target goes straight to the response. A
// finished beat waits in the output register, and the next request is taken while it waits.
// ----------------------------------------------------------------------------
module bitmap_block_inode_allocator_unit #(
  parameter int MAP_BITS          = bbia_pkg::MAP_BITS_DEF,
  parameter int FIRST_INODE_INDEX = bbia_pkg::FIRST_INODE_INDEX_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbia_cfg_if.sink   cfg_i,
  bbia_req_if.sink   req_i,
  bbia_rsp_if.source rsp_o
);
  import bbia_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  cmd_t           cmd;
  sts_t           sts;
  logic [WAW-1:0] addr, start_w, next_w;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  // sequencer
  bbia_ctrl #(
    .MAP_BITS  (MAP_BITS),
    .MAP_WORDS (MAP_WORDS),
    .WAW       (WAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .start_w_i   (start_w),
    .next_w_i    (next_w),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  // maps, counters and response
  bbia_datapath #(
    .MAP_BITS          (MAP_BITS),
    .FIRST_INODE_INDEX (FIRST_INODE_INDEX),
    .MAP_WORDS         (MAP_WORDS),
    .WAW               (WAW)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .op_i              (req_i.operation),
    .target_i          (req_i.target),
    .cmd_i             (cmd),
    .addr_i            (addr),
    .sts_o             (sts),
    .start_w_o         (start_w),
    .next_w_o          (next_w),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_number_o      (rsp_o.number),
    .rsp_status_o      (rsp_o.status),
    .rsp_free_blocks_o (rsp_o.free_blocks),
    .rsp_free_inodes_o (rsp_o.free_inodes),
    .rsp_used_dirs_o   (rsp_o.used_dirs)
  );

endmodule

[verif/bbia_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_alloc_checker
// Watches the register, request and response channels of the allocator. It
// keeps its own copy of both bitmaps, the three counters and the registers,
// works out the response to every accepted request and compares each
// accepted response beat, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bbia_alloc_checker #(
  parameter int MAP_BITS          = bbia_pkg::MAP_BITS_DEF,
  parameter int FIRST_INODE_INDEX = bbia_pkg::FIRST_INODE_INDEX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bbia_cfg_if  cfg_i,
  bbia_req_if  req_i,
  bbia_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import bbia_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] free_inodes;
    logic [CNT_W-1:0] used_dirs;
  } alloc_result_t;

  // shadow bitmaps, counters and registers
  bit               blk_map [MAP_BITS];
  bit               ino_map [MAP_BITS];
  logic [CNT_W-1:0] free_blk_cnt;
  logic [CNT_W-1:0] free_ino_cnt;
  logic [CNT_W-1:0] used_dir_cnt;
  logic [CFG_W-1:0] total_blocks;
  logic [CFG_W-1:0] total_inodes;
  logic [CFG_W-1:0] inodes_per_group;
  logic [CFG_W-1:0] device_blocks;

  alloc_result_t awaited_results [$];
  alloc_result_t got;
  alloc_result_t want;
  int            mismatches;

  function automatic bit block_num_ok(logic [CFG_W:0] n);
    return (n != '0) && (n < {1'b0, total_blocks}) && (n < {1'b0, device_blocks});
  endfunction

  function automatic bit inode_num_ok(logic [CFG_W:0] n);
    return (n != '0) && (n <= {1'b0, total_inodes});
  endfunction

  // apply one request to the shadow state and return its response
  function automatic alloc_result_t apply_request(logic [OP_W-1:0] op,
                                                  logic [TGT_W-1:0] tgt);
    alloc_result_t res;
    logic [CFG_W:0] num;
    int             limit;
    int             idx;
    bit             ok;
    num        = '0;
    res        = '0;
    res.status = ST_NONE;
    case (op)
      OP_ALLOC_BLOCK: begin
        for (int i = 0; i < MAP_BITS; i++) begin
          if (!blk_map[i] && block_num_ok(33'(i) + 33'd1)) begin
            blk_map[i]   = 1'b1;
            free_blk_cnt = free_blk_cnt - 1'b1;
            num          = 33'(i) + 33'd1;
            res.status   = ST_DONE;
            break;
          end
        end
      end
      OP_ALLOC_FILE, OP_ALLOC_DIR: begin
        // scan window is clamped to the map size
        limit = (inodes_per_group > MAP_BITS) ? MAP_BITS : int'(inodes_per_group);
        for (int i = FIRST_INODE_INDEX; i < limit; i++) begin
          if (!ino_map[i] && inode_num_ok(33'(i) + 33'd1)) begin
            ino_map[i]   = 1'b1;
            free_ino_cnt = free_ino_cnt - 1'b1;
            if (op == OP_ALLOC_DIR) used_dir_cnt = used_dir_cnt + 1'b1;
            num        = 33'(i) + 33'd1;
            res.status = ST_DONE;
            break;
          end
        end
      end
      OP_FREE_BLOCK, OP_FREE_INODE: begin
        ok = (op == OP_FREE_BLOCK) ? block_num_ok({1'b0, tgt}) : inode_num_ok({1'b0, tgt});
        // numbers past the map are rejected even when the registers allow them
        if (ok && tgt <= MAP_BITS) begin
          idx = int'(tgt) - 1;
          if (op == OP_FREE_BLOCK) begin
            if (blk_map[idx]) begin
              blk_map[idx] = 1'b0;
              free_blk_cnt = free_blk_cnt + 1'b1;
              res.status   = ST_DONE;
            end else begin
              res.status = ST_ALREADY_CLR;
            end
          end else begin
            if (ino_map[idx]) begin
              ino_map[idx] = 1'b0;
              free_ino_cnt = free_ino_cnt + 1'b1;
              res.status   = ST_DONE;
            end else begin
              res.status = ST_ALREADY_CLR;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.number      = num[NUM_W-1:0];
    res.free_blocks = free_blk_cnt;
    res.free_inodes = free_ino_cnt;
    res.used_dirs   = used_dir_cnt;
    return res;
  endfunction

  // beat monitor: response compare, request prediction, register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAP_BITS; i++) begin
        blk_map[i] = 1'b0;
        ino_map[i] = 1'b0;
      end
      free_blk_cnt     = '0;
      free_ino_cnt     = '0;
      used_dir_cnt     = '0;
      total_blocks     = TOTAL_BLOCKS_RST;
      total_inodes     = TOTAL_INODES_RST;
      inodes_per_group = INODES_PER_GROUP_RST;
      device_blocks    = DEVICE_BLOCKS_RST;
      awaited_results.delete();
      mismatches       = 0;
    end else begin
      // response beat against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        got = {rsp_i.number, rsp_i.status, rsp_i.free_blocks, rsp_i.free_inodes,
               rsp_i.used_dirs};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected response beat: number %0d status %0d fb %0d fi %0d ud %0d",
                     got.number, got.status, got.free_blocks, got.free_inodes,
                     got.used_dirs);
        end else begin
          want = awaited_results.pop_front();
          if (got.number != want.number || got.status != want.status ||
              got.free_blocks != want.free_blocks || got.free_inodes != want.free_inodes ||
              got.used_dirs != want.used_dirs) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp number %0d status %0d fb %0d fi %0d ud %0d, %s%0d %s%0d %s%0d %s%0d %s%0d",
                       want.number, want.status, want.free_blocks, want.free_inodes,
                       want.used_dirs, "got number ", got.number, "status ", got.status,
                       "fb ", got.free_blocks, "fi ", got.free_inodes, "ud ", got.used_dirs);
          end
        end
      end
      // request beat, seen with the registers as they stood before this edge
      if (req_i.valid && req_i.ready)
        awaited_results.push_back(apply_request(req_i.operation, req_i.target));
      // register write beat
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_TOTAL_BLOCKS:     total_blocks     = cfg_i.data;
          REG_TOTAL_INODES:     total_inodes     = cfg_i.data;
          REG_INODES_PER_GROUP: inodes_per_group = cfg_i.data;
          REG_DEVICE_BLOCKS:    device_blocks    = cfg_i.data;
          default: begin
          end
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_results.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bitmap block/inode allocator: a directed pass over the
// edge numbers and every operation at reset settings, then random phases
// under several register settings and idling patterns. A side checker
// predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bbia_pkg::*;

  localparam int MAP_BITS      = MAP_BITS_DEF;
  localparam int RST_CYCLES    = 8;
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 200;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 145;

  // reserved operation codes
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  logic clk_i;
  logic rst_ni;

  bbia_cfg_if cfg_if ();
  bbia_req_if req_if ();
  bbia_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // register settings per phase, with the number spans that frees aim at
  logic [CFG_W-1:0] ph_total_blocks [NUM_PHASES] =
    '{32'd48, 32'd8192, 32'd0, 32'hFFFF_FFFF, 32'd200, 32'd1, 32'd100, 32'd20};
  logic [CFG_W-1:0] ph_total_inodes [NUM_PHASES] =
    '{32'd40, 32'd2048, 32'd0, 32'hFFFF_FFFF, 32'd100, 32'd12, 32'd200, 32'd20};
  logic [CFG_W-1:0] ph_per_group [NUM_PHASES] =
    '{32'd64, 32'd30, 32'd0, 32'hFFFF_FFFF, 32'd11, 32'd10, 32'd150, 32'd8192};
  logic [CFG_W-1:0] ph_device_blocks [NUM_PHASES] =
    '{32'd4096, 32'd33, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64, 32'd20};
  int ph_blk_span [NUM_PHASES] = '{50, 36, 20, 400, 60, 8, 66, 22};
  int ph_ino_span [NUM_PHASES] = '{45, 34, 20, 400, 14, 14, 152, 22};

  bitmap_block_inode_allocator_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bbia_alloc_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // response side back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat, after a random idle gap; valid stays high afterwards
  task automatic push_req(input logic [OP_W-1:0] op, input logic [TGT_W-1:0] tgt);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.target    <= tgt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // one register write beat; valid stays high afterwards
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // free target: mostly inside the live span, some edges, some anything
  function automatic logic [TGT_W-1:0] pick_target(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return TGT_W'($urandom_range(1, span + 2));
    if (r < 85) begin
      case ($urandom_range(0, 7))
        0:       return '0;
        1:       return 32'd1;
        2:       return TGT_W'(span);
        3:       return TGT_W'(span + 1);
        4:       return TGT_W'(MAP_BITS - 1);
        5:       return TGT_W'(MAP_BITS);
        6:       return TGT_W'(MAP_BITS + 1);
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // stimulus
  initial begin
    int               r;
    logic [OP_W-1:0]  op;
    logic [TGT_W-1:0] tgt;
    rst_ni           = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_TOTAL_BLOCKS;
    cfg_if.data      = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ALLOC_BLOCK;
    req_if.target    = '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pass at reset settings
    push_req(OP_FREE_BLOCK, 32'd1);
    push_req(OP_FREE_INODE, 32'd11);
    push_req(OP_ALLOC_BLOCK, 32'd0);
    push_req(OP_ALLOC_FILE, 32'd0);
    push_req(OP_ALLOC_DIR, 32'hFFFF_FFFF);
    push_req(OP_FREE_BLOCK, 32'd1);
    push_req(OP_FREE_BLOCK, 32'd1);
    push_req(OP_FREE_BLOCK, 32'd0);
    push_req(OP_FREE_BLOCK, 32'd8191);
    push_req(OP_FREE_BLOCK, 32'd8192);
    push_req(OP_FREE_BLOCK, 32'hFFFF_FFFF);
    push_req(OP_FREE_INODE, 32'd0);
    push_req(OP_FREE_INODE, 32'd2048);
    push_req(OP_FREE_INODE, 32'd2049);
    // directory inode freed: directory count stays
    push_req(OP_FREE_INODE, 32'd12);
    push_req(OP_FREE_INODE, 32'hFFFF_FFFF);
    for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++) push_req(OP_W'(c), $urandom());
    push_req(OP_ALLOC_BLOCK, 32'hFFFF_FFFF);
    push_req(OP_ALLOC_FILE, 32'hFFFF_FFFF);
    req_if.valid <= 1'b0;

    // random phases, each under its own registers and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      // let the count of the last request beat settle before waiting on it
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
      write_reg(REG_TOTAL_BLOCKS, ph_total_blocks[p]);
      write_reg(REG_TOTAL_INODES, ph_total_inodes[p]);
      write_reg(REG_INODES_PER_GROUP, ph_per_group[p]);
      write_reg(REG_DEVICE_BLOCKS, ph_device_blocks[p]);
      cfg_if.valid <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 30)      op = OP_ALLOC_BLOCK;
        else if (r < 50) op = OP_FREE_BLOCK;
        else if (r < 62) op = OP_ALLOC_FILE;
        else if (r < 72) op = OP_ALLOC_DIR;
        else if (r < 94) op = OP_FREE_INODE;
        else             op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        if (op == OP_FREE_BLOCK)      tgt = pick_target(ph_blk_span[p]);
        else if (op == OP_FREE_INODE) tgt = pick_target(ph_ino_span[p]);
        else                          tgt = $urandom();
        push_req(op, tgt);
      end
      req_if.valid <= 1'b0;
    end

    // drain, settle, verdict
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
